FILE: src/bsmm_pkg.sv
// ----------------------------------------------------------------------------
// Boolean sparse matrix multiply package
// Sizes, operation codes, register indexes and the small helper functions
// used by the row-by-row Boolean product engine.
// ----------------------------------------------------------------------------
package bsmm_pkg;

    // Largest inner dimension and output width.
    localparam int MAX_DIM  = 64;
    localparam int DIM_W    = $clog2(MAX_DIM);
    // Configuration registers are wide enough to hold MAX_DIM itself.
    localparam int REG_W    = 7;
    // Result rows are counted modulo MAX_ROWS.
    localparam int MAX_ROWS = 65536;
    localparam int ROW_W    = 16;

    // Operation codes of an input word.
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_ENTRY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_INNER_DIM = 1'b0;
    localparam logic CFG_OUT_WIDTH = 1'b1;

    typedef logic [MAX_DIM-1:0] t_bit_row;
    typedef logic [DIM_W-1:0]   t_index;
    typedef logic [REG_W-1:0]   t_size;

    // Register value saturated to MAX_DIM.
    function automatic t_size eff_size(input t_size reg_value);
        t_size lim;
        lim = REG_W'(MAX_DIM);
        return (reg_value > lim) ? lim : reg_value;
    endfunction

    // Mask with the lowest 'w' bits set.
    function automatic t_bit_row low_mask(input t_size w);
        t_bit_row ones;
        ones = '1;
        if (w >= REG_W'(MAX_DIM)) begin
            return ones;
        end
        return (t_bit_row'(1) << w[DIM_W-1:0]) - t_bit_row'(1);
    endfunction

    // Bit position of a one-hot word.
    function automatic t_index onehot_index(input t_bit_row oh);
        t_index idx;
        idx = '0;
        for (int i = 0; i < MAX_DIM; i++) begin
            if (oh[i]) begin
                idx = idx | DIM_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

FILE: src/boolean_sparse_matrix_multiply.sv
// ----------------------------------------------------------------------------
// Boolean sparse matrix multiply
// A load or an entry reads the B row, then writes it or ORs it into the accumulator; a bad
// load or a bad entry inside a row sends an error word instead. A clear, an unused code or
// an entry-less word inside a row is done on acceptance. A row end masks the accumulator,
// then the lowest-set-bit scanner sends one result word (1 to 64) per cycle unless stalled.
// Reset (synchronous, active low) empties B, the accumulator and row count.
// ----------------------------------------------------------------------------
module boolean_sparse_matrix_multiply (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Configuration write port.
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_addr,
    input  logic [bsmm_pkg::REG_W-1:0]   i_cfg_wdata,
    // Input stream.
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [15:0]                  s_axis_tdata,  // b_row[5:0], col_index[11:6]
    input  logic [2:0]                   s_axis_tuser,  // opcode[1:0], has_entry[2]
    input  logic                         s_axis_tlast,  // row_last
    // Result stream.
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [23:0]                  m_axis_tdata,  // row_number[15:0], column[21:16]
    output logic [1:0]                   m_axis_tuser,  // row_empty[0], index_error[1]
    output logic                         m_axis_tlast   // last_of_row
);
    import bsmm_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_ACC   = 3'd2;
    localparam logic [2:0] S_PREP  = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;
    localparam logic [2:0] S_ERR   = 3'd5;

    // B row memory with per-row valid bits; an invalid row reads as zero.
    t_bit_row             r_mem [MAX_DIM];
    t_bit_row             r_rdata;
    logic                 r_rd_vld;
    logic [MAX_DIM-1:0]   r_row_vld;

    logic [2:0]           r_state;
    t_size                r_inner_dim;
    t_size                r_out_width;
    t_bit_row             r_acc;
    t_bit_row             r_scan;
    logic                 r_empty;
    logic                 r_err;
    logic                 r_last_in;
    t_index               r_brow;
    t_index               r_col;
    logic [ROW_W-1:0]     r_row_cnt;

    // Output register.
    logic                 r_out_vld;
    logic [ROW_W-1:0]     r_out_row;
    t_index               r_out_col;
    logic                 r_out_last;
    logic                 r_out_empty;
    logic                 r_out_err;

    // Input word fields.
    logic [1:0]           in_op;
    t_index               in_brow;
    t_index               in_col;
    logic                 in_has;
    logic                 accept;
    logic                 slot_free;
    logic                 emit_now;
    t_size                idim;
    t_size                owid;
    logic                 load_bad;
    logic                 entry_bad;

    // Scanner: lowest set bit and what remains.
    t_bit_row             low_bit;
    t_bit_row             rest;
    t_bit_row             row_data;
    logic [ROW_W-1:0]     n_row_cnt;

    assign in_brow   = s_axis_tdata[DIM_W-1:0];
    assign in_col    = s_axis_tdata[2*DIM_W-1:DIM_W];
    assign in_op     = s_axis_tuser[1:0];
    assign in_has    = s_axis_tuser[2];
    assign s_axis_tready = (r_state == S_IDLE);
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign slot_free = !r_out_vld || m_axis_tready;
    assign emit_now  = slot_free && ((r_state == S_EMIT) || (r_state == S_ERR));

    assign idim      = eff_size(r_inner_dim);
    assign owid      = eff_size(r_out_width);
    assign load_bad  = ({1'b0, in_brow} >= idim) || ({1'b0, in_col} >= owid);
    assign entry_bad = in_has && ({1'b0, in_col} >= idim);

    assign low_bit   = r_scan & (~r_scan + t_bit_row'(1));
    assign rest      = r_scan ^ low_bit;
    assign row_data  = r_rd_vld ? r_rdata : '0;
    assign n_row_cnt = (r_row_cnt == ROW_W'(MAX_ROWS - 1)) ? '0 : r_row_cnt + 1'b1;

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {2'b00, r_out_col, r_out_row};
    assign m_axis_tuser  = {r_out_err, r_out_empty};
    assign m_axis_tlast  = r_out_last;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inner_dim <= REG_W'(64);
            r_out_width <= REG_W'(64);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_INNER_DIM: r_inner_dim <= i_cfg_wdata;
                CFG_OUT_WIDTH: r_out_width <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Memory read and write ports.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rdata  <= r_mem[(in_op == OP_LOAD) ? in_brow : in_col];
            r_rd_vld <= r_row_vld[(in_op == OP_LOAD) ? in_brow : in_col];
        end
        if (r_state == S_LOAD) begin
            r_mem[r_brow] <= row_data | (t_bit_row'(1) << r_col);
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_row_vld <= '0;
            r_acc     <= '0;
            r_row_cnt <= '0;
            r_out_vld <= 1'b0;
            r_err     <= 1'b0;
        end else begin
            // A taken word frees the output register unless a new word replaces it.
            if (m_axis_tready && !emit_now) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_brow    <= in_brow;
                        r_col     <= in_col;
                        r_last_in <= s_axis_tlast;
                        unique case (in_op)
                            OP_LOAD: begin
                                r_err   <= 1'b1;
                                r_state <= load_bad ? S_ERR : S_LOAD;
                            end
                            OP_ENTRY: begin
                                r_err <= entry_bad;
                                if (in_has && !entry_bad) begin
                                    r_state <= S_ACC;
                                end else if (s_axis_tlast) begin
                                    r_state <= S_PREP;
                                end else if (entry_bad) begin
                                    r_state <= S_ERR;
                                end
                            end
                            OP_CLEAR: begin
                                r_row_vld <= '0;
                                r_acc     <= '0;
                                r_row_cnt <= '0;
                            end
                            OP_NONE: ;
                            default: ;
                        endcase
                    end
                end
                S_LOAD: begin
                    r_row_vld[r_brow] <= 1'b1;
                    r_state           <= S_IDLE;
                end
                S_ACC: begin
                    r_acc   <= r_acc | row_data;
                    r_state <= r_last_in ? S_PREP : S_IDLE;
                end
                S_PREP: begin
                    r_scan  <= r_acc & low_mask(owid);
                    r_empty <= (r_acc & low_mask(owid)) == '0;
                    r_acc   <= '0;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (slot_free) begin
                        r_out_vld   <= 1'b1;
                        r_out_row   <= r_row_cnt;
                        r_out_err   <= r_err;
                        r_out_empty <= r_empty;
                        r_out_col   <= r_empty ? '0 : onehot_index(low_bit);
                        r_out_last  <= r_empty || (rest == '0);
                        r_scan      <= rest;
                        if (r_empty || (rest == '0)) begin
                            r_row_cnt <= n_row_cnt;
                            r_state   <= S_IDLE;
                        end
                    end
                end
                S_ERR: begin
                    if (slot_free) begin
                        r_out_vld   <= 1'b1;
                        r_out_row   <= r_row_cnt;
                        r_out_err   <= 1'b1;
                        r_out_empty <= 1'b0;
                        r_out_col   <= '0;
                        r_out_last  <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: src/bsmm_checker.sv
// ----------------------------------------------------------------------------
// Boolean sparse matrix multiply port checker
// Watches the top level's ports and flags result words that break the
// stream rules or the meaning of the result flags.
// ----------------------------------------------------------------------------
module bsmm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // A stalled result word holds its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result word changed while stalled");

    // Reset leaves no result word pending.
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result word pending after reset");

    // An empty row is a single word that ends the row, with column zero.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            m_axis_tlast && (m_axis_tdata[21:16] == 6'd0))
        else $error("empty row word malformed");

    // A word that does not end a row, a column or a lone error word, never carries the empty flag.
    a_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !m_axis_tuser[0])
        else $error("empty flag on a word that does not end the row");

endmodule

bind boolean_sparse_matrix_multiply bsmm_checker u_bsmm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
